[hdl/heading_bang_bang_steer_defines.svh]
// Assertion macros shared by the steering block.
`ifndef HEADING_BANG_BANG_STEER_DEFINES_SVH
`define HEADING_BANG_BANG_STEER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HBBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HBBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/hbbs_pkg.sv]
// Constants, widths and angle table for the heading steering block.
package hbbs_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int MAX_STEPS           = 24;

    // angle accumulator: Q24 degrees, +-280 deg fits 10 integer bits
    localparam int Z_FRAC = 24;
    localparam int Z_W    = 34;
    // vector coordinates: 17-bit deltas grown by CORDIC gain, Q24
    localparam int DELTA_W = 17;
    localparam int XY_W    = 44;

    localparam logic signed [Z_W-1:0] Z_POS_180 = 34'sd3019898880;
    localparam logic signed [Z_W-1:0] Z_NEG_180 = -34'sd3019898880;

    // atan(2^-i) in Q24 degrees
    localparam logic signed [Z_W-1:0] ATAN_Q24 [0:MAX_STEPS-1] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489089, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509719,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115
    };

    // heading fold
    localparam logic signed [9:0] HEAD_HALF = 10'sd180;
    localparam logic signed [9:0] HEAD_FULL = 10'sd360;

    // register indexes
    localparam logic [1:0] CFG_TURN_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_TURN_SPEED     = 2'd1;
    localparam logic [1:0] CFG_STRAIGHT_SPEED = 2'd2;

    localparam logic [7:0] RST_TURN_THRESHOLD = 8'd20;
    localparam logic [8:0] RST_TURN_SPEED     = 9'd100;
    localparam logic [8:0] RST_STRAIGHT_SPEED = 9'd200;

    // steer modes
    localparam logic [1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [1:0] MODE_LEFT     = 2'd1;
    localparam logic [1:0] MODE_RIGHT    = 2'd2;

endpackage

[hdl/heading_bang_bang_steer.sv]
// Bang-bang steering toward a target from a pipelined CORDIC atan2 bearing.
// Each CORDIC step has its own adder stage; from input beat to result the stages are:
//   one setup stage, one stage per CORDIC step, a rounding stage, the output register.
// Throughput: one beat per cycle while a low i_out_ready does not stall the output.
// Reset (synchronous, active low) empties the pipeline and reloads the registers
//   with threshold 20, turn speed 100, straight speed 200.
`include "heading_bang_bang_steer_defines.svh"

module heading_bang_bang_steer #(
    parameter int ANGLE_FRAC_BITS = hbbs_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = hbbs_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_robot_x,
    input  logic signed [15:0] i_robot_y,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic [8:0]         i_heading_raw,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [9:0]  o_left_speed,
    output logic signed [9:0]  o_right_speed,
    output logic [1:0]         o_steer_mode
);

    localparam int XY_W   = hbbs_pkg::XY_W;
    localparam int Z_W    = hbbs_pkg::Z_W;
    localparam int Z_FRAC = hbbs_pkg::Z_FRAC;
    localparam int DW     = hbbs_pkg::DELTA_W;
    localparam int N      = CORDIC_STEPS;
    localparam int B_W    = Z_W - Z_FRAC + ANGLE_FRAC_BITS;
    localparam int D_W    = B_W + 1;
    localparam logic signed [Z_W-1:0] ROUND_HALF =
        {{(Z_W-1){1'b0}}, 1'b1} << (Z_FRAC - ANGLE_FRAC_BITS - 1);

    // ---------------- configuration registers ----------------
    logic [7:0] r_thr;
    logic [8:0] r_turn;
    logic [8:0] r_straight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= hbbs_pkg::RST_TURN_THRESHOLD;
            r_turn     <= hbbs_pkg::RST_TURN_SPEED;
            r_straight <= hbbs_pkg::RST_STRAIGHT_SPEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hbbs_pkg::CFG_TURN_THRESHOLD: r_thr      <= i_cfg_data[7:0];
                hbbs_pkg::CFG_TURN_SPEED:     r_turn     <= i_cfg_data;
                hbbs_pkg::CFG_STRAIGHT_SPEED: r_straight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline storage ----------------
    logic                   r_v    [0:N];
    logic signed [XY_W-1:0] r_x    [0:N];
    logic signed [XY_W-1:0] r_y    [0:N];
    logic signed [Z_W-1:0]  r_z    [0:N];
    logic signed [9:0]      r_h    [0:N];
    logic                   r_zero [0:N];

    logic                   r_rnd_valid;
    logic signed [B_W-1:0]  r_rnd_b;
    logic signed [9:0]      r_rnd_h;

    logic                   r_out_valid;
    logic signed [9:0]      r_left;
    logic signed [9:0]      r_right;
    logic [1:0]             r_mode;

    // a stage loads when it is empty or its contents move on
    logic       w_load [0:N];
    logic       w_load_rnd;
    logic       w_load_out;

    assign w_load_out = !r_out_valid || i_out_ready;
    assign w_load_rnd = !r_rnd_valid || w_load_out;
    assign w_load[N]  = !r_v[N] || w_load_rnd;

    for (genvar k = 0; k < N; k++) begin : g_load
        assign w_load[k] = !r_v[k] || w_load[k+1];
    end

    assign o_in_ready = w_load[0];

    // ---------------- setup stage ----------------
    logic signed [DW-1:0]   w_dx, w_dy, w_ndx, w_ndy;
    logic signed [DW-1:0]   w_x0, w_y0;
    logic signed [Z_W-1:0]  n_z0;
    logic signed [9:0]      n_h0;

    always_comb begin
        w_dx  = DW'(i_target_x) - DW'(i_robot_x);
        w_dy  = DW'(i_target_y) - DW'(i_robot_y);
        w_ndx = DW'(i_robot_x) - DW'(i_target_x);
        w_ndy = DW'(i_robot_y) - DW'(i_target_y);
        // left half-plane: rotate by 180 and start the angle at +-180
        if (w_dx[DW-1]) begin
            w_x0 = w_ndx;
            w_y0 = w_ndy;
            n_z0 = w_dy[DW-1] ? hbbs_pkg::Z_NEG_180 : hbbs_pkg::Z_POS_180;
        end else begin
            w_x0 = w_dx;
            w_y0 = w_dy;
            n_z0 = '0;
        end
        n_h0 = signed'({1'b0, i_heading_raw});
        if (n_h0 > hbbs_pkg::HEAD_HALF) begin
            n_h0 = n_h0 - hbbs_pkg::HEAD_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_load[0]) begin
            r_v[0] <= i_in_valid;
        end
        if (w_load[0]) begin
            r_x[0]    <= XY_W'(w_x0) <<< Z_FRAC;
            r_y[0]    <= XY_W'(w_y0) <<< Z_FRAC;
            r_z[0]    <= n_z0;
            r_h[0]    <= n_h0;
            r_zero[0] <= (w_dx == '0) && (w_dy == '0);
        end
    end

    // ---------------- CORDIC vectoring steps ----------------
    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [XY_W-1:0] w_xs;
        logic signed [XY_W-1:0] w_ys;

        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (w_load[i+1]) begin
                r_v[i+1] <= r_v[i];
            end
            if (w_load[i+1]) begin
                if (!r_y[i][XY_W-1]) begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + hbbs_pkg::ATAN_Q24[i];
                end else begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - hbbs_pkg::ATAN_Q24[i];
                end
                r_h[i+1]    <= r_h[i];
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // ---------------- rounding stage ----------------
    logic signed [Z_W-1:0] w_zr;
    logic signed [B_W-1:0] n_rnd_b;

    assign w_zr    = r_z[N] + ROUND_HALF;
    assign n_rnd_b = r_zero[N] ? '0 : signed'(w_zr[Z_W-1:Z_FRAC-ANGLE_FRAC_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
        end else if (w_load_rnd) begin
            r_rnd_valid <= r_v[N];
        end
        if (w_load_rnd) begin
            r_rnd_b <= n_rnd_b;
            r_rnd_h <= r_h[N];
        end
    end

    // ---------------- decision and output register ----------------
    logic signed [D_W-1:0] w_diff;
    logic signed [D_W-1:0] w_thr;
    logic signed [D_W-1:0] w_nthr;
    logic signed [9:0]     w_turn;
    logic signed [9:0]     w_straight;
    logic signed [9:0]     n_left;
    logic signed [9:0]     n_right;
    logic [1:0]            n_mode;

    always_comb begin
        w_diff     = D_W'(r_rnd_b) - (D_W'(r_rnd_h) <<< ANGLE_FRAC_BITS);
        w_thr      = signed'(D_W'(r_thr)) <<< ANGLE_FRAC_BITS;
        w_nthr     = -w_thr;
        w_turn     = signed'({1'b0, r_turn});
        w_straight = signed'({1'b0, r_straight});
        if (w_diff < w_nthr) begin
            n_left  = -w_turn;
            n_right = w_turn;
            n_mode  = hbbs_pkg::MODE_LEFT;
        end else if (w_diff > w_thr) begin
            n_left  = w_turn;
            n_right = -w_turn;
            n_mode  = hbbs_pkg::MODE_RIGHT;
        end else begin
            n_left  = w_straight;
            n_right = w_straight;
            n_mode  = hbbs_pkg::MODE_STRAIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= r_rnd_valid;
        end
        if (w_load_out) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_mode  <= n_mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;
    assign o_steer_mode  = r_mode;

    // ---------------- assertions ----------------
    `HBBS_ASSERT_NEXT(a_accept_lands, i_in_valid && o_in_ready, r_v[0], "accepted beat lost at entry")
    `HBBS_ASSERT_NEXT(a_zero_bearing, r_v[N] && r_zero[N] && w_load_rnd, r_rnd_b == '0, "zero vector bearing not zero")
    `HBBS_ASSERT_NOW(a_turn_opposed, o_out_valid && (o_steer_mode == hbbs_pkg::MODE_LEFT || o_steer_mode == hbbs_pkg::MODE_RIGHT), (o_left_speed + o_right_speed) == '0, "turn speeds not opposed")
    `HBBS_ASSERT_NOW(a_straight_equal, o_out_valid && o_steer_mode == hbbs_pkg::MODE_STRAIGHT, o_left_speed == o_right_speed, "straight speeds differ")

endmodule
